// ----- design/pdm_to_pcm_fir_decimator_core_defines.svh -----
// Assertion macros shared by the PDM to PCM decimator RTL.
`ifndef PDM_TO_PCM_FIR_DECIMATOR_CORE_DEFINES_SVH
`define PDM_TO_PCM_FIR_DECIMATOR_CORE_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define PDMFIR_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define PDMFIR_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/pdmfir_pkg.sv -----
// Package: sizes, register indexes and controller/datapath types for the decimator.
`default_nettype none

package pdmfir_pkg;

  // Filter geometry
  localparam int TAPS        = 16;
  localparam int SCALE_BITS  = 30;
  localparam int COEFF_WIDTH = 32;

  localparam int ROWS        = 2 * TAPS;
  localparam int TABLE_DEPTH = ROWS * 256;
  localparam int SLOT_W      = $clog2(TAPS);
  localparam int ROW_W       = $clog2(ROWS);
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);

  // Post-filter widths: the smallest shift is SCALE_BITS + 1 - 15
  localparam int SHIFT_W = 32 - (SCALE_BITS - 14);
  localparam int V1_W    = ((SHIFT_W > 16) ? SHIFT_W : 16) + 1;
  localparam int PROD_W  = V1_W + 17;
  localparam int SH_W    = 6;

  // Ring reset pattern
  localparam logic [15:0] RING_RESET = 16'h5555;

  // Configuration port
  localparam int CFG_IDX_W = 3;
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DECIMATION_WORDS = 3'd0,
    REG_INPUT_OFFSET     = 3'd1,
    REG_OUTPUT_OFFSET    = 3'd2,
    REG_LINEAR_GAIN      = 3'd3,
    REG_BIT_SCALE        = 3'd4
  } pdmfir_reg_t;

  // Input item kinds
  localparam logic FUNC_PDM   = 1'b0;
  localparam logic FUNC_COEFF = 1'b1;

  // Commands from controller to datapath
  typedef struct packed {
    logic accept_en;  // input channel may take a beat
    logic issue;      // issue one table lookup
    logic scale;      // shift total and add input offset
    logic mult;       // apply gain
    logic load;       // clamp, offset, mask into output register
  } pdmfir_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic take_sample;  // accepted PDM word completes a group
    logic issue_last;   // lookup counter at its final row
    logic out_free;     // output register can take a sample
  } pdmfir_status_t;

endpackage

`default_nettype wire

// ----- design/pdmfir_ifs.sv -----
// Valid/ready channel interfaces: PDM input, PCM output, configuration writes.
`default_nettype none

interface pdmfir_in_if
  import pdmfir_pkg::*;
  ();
  logic        valid;
  logic        ready;
  logic        func;
  logic [15:0] pdm_word;
  logic [4:0]  coeff_row;
  logic [7:0]  coeff_byte;
  logic signed [31:0] coeff_value;

  modport source (output valid, func, pdm_word, coeff_row, coeff_byte, coeff_value,
                  input ready);
  modport sink   (input valid, func, pdm_word, coeff_row, coeff_byte, coeff_value,
                  output ready);
endinterface

interface pdmfir_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] pcm_sample;

  modport source (output valid, pcm_sample, input ready);
  modport sink   (input valid, pcm_sample, output ready);
endinterface

interface pdmfir_cfg_if
  import pdmfir_pkg::*;
  ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [15:0]          data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- design/pdmfir_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module pdmfir_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- design/pdmfir_ctrl.sv -----
// Sequencer: lookup sweep, scaling, gain and output load for each sample.
`default_nettype none

module pdmfir_ctrl
  import pdmfir_pkg::*;
(
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire pdmfir_status_t st,
  output pdmfir_cmd_t         cmd
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_LOOK  = 6'b000010,
    S_DRAIN = 6'b000100,
    S_SCALE = 6'b001000,
    S_MULT  = 6'b010000,
    S_EMIT  = 6'b100000
  } state_t;

  state_t state, state_next;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (st.take_sample) state_next = S_LOOK;
      S_LOOK:  if (st.issue_last)  state_next = S_DRAIN;
      S_DRAIN: state_next = S_SCALE;
      S_SCALE: state_next = S_MULT;
      S_MULT:  state_next = S_EMIT;
      S_EMIT:  if (st.out_free)    state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Commands
  always_comb begin
    cmd.accept_en = (state == S_IDLE);
    cmd.issue     = (state == S_LOOK);
    cmd.scale     = (state == S_SCALE);
    cmd.mult      = (state == S_MULT);
    cmd.load      = (state == S_EMIT) && st.out_free;
  end

endmodule

`default_nettype wire

// ----- design/pdmfir_dp.sv -----
// Datapath: tap ring, group count, coefficient table, accumulator and output stage.
`default_nettype none

module pdmfir_dp
  import pdmfir_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  pdmfir_in_if.sink        pdm_in,
  pdmfir_out_if.source     pcm_out,
  pdmfir_cfg_if.sink       cfg,
  input  wire pdmfir_cmd_t cmd,
  output pdmfir_status_t   st
);

  // Configuration registers
  logic [4:0]         dec_words;
  logic signed [15:0] in_offset;
  logic signed [15:0] out_offset;
  logic [15:0]        gain;
  logic [3:0]         out_res;

  // Filter state
  logic [15:0]       tap_ring [TAPS];
  logic [SLOT_W-1:0] write_slot;
  logic [3:0]        words_in_group;

  // Lookup sweep and accumulator
  logic [ROW_W-1:0]   lookup_cnt;
  logic               lookup_pend;
  logic [31:0]        acc;
  logic signed [V1_W-1:0]   v1;
  logic signed [PROD_W-1:0] prod;

  // Output register
  logic        out_valid;
  logic [15:0] out_data;

  logic                   in_beat;
  logic                   pdm_beat;
  logic                   coeff_we;
  logic [4:0]             dw_eff;
  logic [4:0]             wig_inc;
  logic                   due;
  logic [3:0]             bs_eff;
  logic [SH_W-1:0]        sh;
  logic [SLOT_W:0]        slot_sum;
  logic [SLOT_W-1:0]      ring_idx;
  logic [15:0]            ring_word;
  logic [7:0]             lookup_byte;
  logic [ADDR_W-1:0]      raddr;
  logic [ADDR_W-1:0]      waddr;
  logic [COEFF_WIDTH-1:0] rdata;
  logic signed [31:0]     shifted;
  logic signed [PROD_W-1:0] lim;
  logic signed [PROD_W-1:0] clamp_hi;
  logic signed [PROD_W-1:0] clamp_lo;
  logic signed [PROD_W-1:0] clamped;
  logic signed [16:0]     out_sum;
  logic [16:0]            out_mask;

  // Handshake
  assign pdm_in.ready  = cmd.accept_en;
  assign cfg.ready     = 1'b1;
  assign in_beat       = pdm_in.valid && pdm_in.ready;
  assign pdm_beat      = in_beat && (pdm_in.func == FUNC_PDM);
  assign coeff_we      = in_beat && (pdm_in.func == FUNC_COEFF)
                         && (32'(pdm_in.coeff_row) < ROWS);

  // Group length: zero acts as one, saturates at sixteen
  always_comb begin
    priority if (dec_words == 5'd0) begin
      dw_eff = 5'd1;
    end else if (dec_words > 5'd16) begin
      dw_eff = 5'd16;
    end else begin
      dw_eff = dec_words;
    end
  end

  assign wig_inc = {1'b0, words_in_group} + 5'd1;
  assign due     = (wig_inc >= dw_eff);

  assign st.take_sample = pdm_beat && due;
  assign st.issue_last  = (lookup_cnt == ROW_W'(ROWS - 1));
  assign st.out_free    = !out_valid || pcm_out.ready;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      dec_words  <= 5'd4;
      in_offset  <= '0;
      out_offset <= '0;
      gain       <= 16'd1;
      out_res    <= 4'd15;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        REG_DECIMATION_WORDS: dec_words  <= cfg.data[4:0];
        REG_INPUT_OFFSET:     in_offset  <= signed'(cfg.data);
        REG_OUTPUT_OFFSET:    out_offset <= signed'(cfg.data);
        REG_LINEAR_GAIN:      gain       <= cfg.data;
        REG_BIT_SCALE:        out_res    <= cfg.data[3:0];
        default: ;
      endcase
    end
  end

  // Ring and group count
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TAPS; i++) begin
        tap_ring[i] <= RING_RESET;
      end
      write_slot     <= '0;
      words_in_group <= '0;
    end else if (pdm_beat) begin
      tap_ring[write_slot] <= pdm_in.pdm_word;
      write_slot           <= (32'(write_slot) == TAPS - 1) ? '0 : write_slot + SLOT_W'(1);
      words_in_group       <= due ? 4'd0 : wig_inc[3:0];
    end
  end

  // Lookup address: oldest word first, high byte then low byte
  assign slot_sum    = {1'b0, write_slot} + {1'b0, lookup_cnt[ROW_W-1:1]};
  assign ring_idx    = (32'(slot_sum) >= TAPS) ? SLOT_W'(32'(slot_sum) - TAPS)
                                               : slot_sum[SLOT_W-1:0];
  assign ring_word   = tap_ring[ring_idx];
  assign lookup_byte = lookup_cnt[0] ? ring_word[7:0] : ring_word[15:8];
  assign raddr       = {lookup_cnt, lookup_byte};
  assign waddr       = {pdm_in.coeff_row[ROW_W-1:0], pdm_in.coeff_byte};

  pdmfir_ram #(
    .WIDTH (COEFF_WIDTH),
    .DEPTH (TABLE_DEPTH)
  ) u_coeff_ram (
    .clk   (clk),
    .we    (coeff_we),
    .waddr (waddr),
    .wdata (pdm_in.coeff_value[COEFF_WIDTH-1:0]),
    .re    (cmd.issue),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Sweep counter and wrapping accumulator
  always_ff @(posedge clk) begin
    if (rst) begin
      lookup_cnt  <= '0;
      lookup_pend <= 1'b0;
    end else begin
      lookup_pend <= cmd.issue;
      if (st.take_sample) begin
        lookup_cnt <= '0;
      end else if (cmd.issue) begin
        lookup_cnt <= lookup_cnt + ROW_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (st.take_sample) begin
      acc <= '0;
    end else if (lookup_pend) begin
      acc <= acc + 32'(signed'(rdata));
    end
  end

  // Scaling: arithmetic shift then input offset
  assign bs_eff  = (out_res == 4'd0) ? 4'd1 : out_res;
  assign sh      = SH_W'(SCALE_BITS + 1) - SH_W'(bs_eff);
  assign shifted = signed'(acc) >>> sh;

  always_ff @(posedge clk) begin
    if (cmd.scale) begin
      v1 <= V1_W'(signed'(shifted[SHIFT_W-1:0])) + V1_W'(in_offset);
    end
    if (cmd.mult) begin
      prod <= PROD_W'(v1) * PROD_W'(signed'({1'b0, gain}));
    end
  end

  // Clamp to signed resolution bits, output offset, mask
  assign lim      = PROD_W'(1) <<< (bs_eff - 4'd1);
  assign clamp_hi = lim - PROD_W'(1);
  assign clamp_lo = -lim;

  always_comb begin
    priority if (prod > clamp_hi) begin
      clamped = clamp_hi;
    end else if (prod < clamp_lo) begin
      clamped = clamp_lo;
    end else begin
      clamped = prod;
    end
  end

  // Mask width reaches 16 bits, so the shift amount needs five bits
  assign out_sum  = 17'(signed'(clamped[15:0])) + 17'(out_offset);
  assign out_mask = (17'd1 << ({1'b0, bs_eff} + 5'd1)) - 17'd1;

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load) begin
      out_valid <= 1'b1;
    end else if (pcm_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_data <= 16'(out_sum & signed'(out_mask));
    end
  end

  assign pcm_out.valid      = out_valid;
  assign pcm_out.pcm_sample = out_data;

endmodule

`default_nettype wire

// ----- design/pdm_to_pcm_fir_decimator_core.sv -----
// PDM to PCM lookup-table FIR decimator: top level joining controller and datapath.
//
// Channels: pdm_in takes PDM words (func 0) and coefficient table writes
// (func 1); pcm_out delivers PCM samples; cfg writes the five registers and
// is always ready. All are valid/ready; a beat moves when both are high.
// A table write or a PDM word that does not close a group leaves the controller idle.
// A word that closes a group starts a sweep of 32 table lookups through the
// coefficient RAM read port, one per cycle, then shift/offset, gain multiply
// and clamp stages; pdm_in drops ready until the sample is loaded into the
// output register.
// The result sits in an output register; further beats are taken while it
// waits. If the receiver stalls, the next sample holds in the final stage
// until the register frees up, and pdm_in stays not ready meanwhile.
// Reset (rst, synchronous) fills the ring with 0x5555, clears the slot and
// group count and restores register defaults. The coefficient table is not
// cleared: every entry must be written before a sample reads it.
`default_nettype none

`include "pdm_to_pcm_fir_decimator_core_defines.svh"

module pdm_to_pcm_fir_decimator_core
  import pdmfir_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  pdmfir_in_if.sink    pdm_in,
  pdmfir_out_if.source pcm_out,
  pdmfir_cfg_if.sink   cfg
);

  pdmfir_cmd_t    cmd;
  pdmfir_status_t st;

  pdmfir_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .st  (st),
    .cmd (cmd)
  );

  pdmfir_dp u_dp (
    .clk     (clk),
    .rst     (rst),
    .pdm_in  (pdm_in),
    .pcm_out (pcm_out),
    .cfg     (cfg),
    .cmd     (cmd),
    .st      (st)
  );

  // A beat that closes a group stops further input for the sweep
  `PDMFIR_ASSERT_NXT(a_busy_after_sample, clk, rst, st.take_sample, !pdm_in.ready, "input ready during sweep")

  // The sweep stops after its final row
  `PDMFIR_ASSERT_NXT(a_sweep_ends, clk, rst, cmd.issue && st.issue_last, !cmd.issue, "lookup past last row")

  // A pending sample is never overwritten
  `PDMFIR_ASSERT_IMP(a_no_overwrite, clk, rst, cmd.load, !pcm_out.valid || pcm_out.ready, "output overwritten")

  // No lookup is issued while input is open
  `PDMFIR_ASSERT_IMP(a_issue_excl, clk, rst, cmd.issue, !pdm_in.ready, "lookup while accepting input")

endmodule

`default_nettype wire

// ----- tb/sv/pdm_to_pcm_fir_decimator_core_tb.sv -----
// Self-checking testbench for the PDM to PCM lookup-table FIR decimator core.
module pdm_to_pcm_fir_decimator_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pdmfir_pkg::*;

  localparam int HALF_PERIOD   = 6;
  localparam int RESET_CYCLES  = 8;
  localparam int STALL_LIMIT   = 2000;
  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_CYCLES  = 64;
  localparam int PHASES        = 8;
  localparam int PHASE_BEATS   = 135;

  // Byte values that PDM words are built from; the initial fill covers only these table columns
  localparam int SET_SIZE = 16;
  localparam logic [8*SET_SIZE-1:0] BYTE_SET = 128'h00FF55A5_80010FF0_3CC3127E_81AA69E4;

  typedef struct packed {
    logic        func;
    logic [15:0] word;
    logic [4:0]  row;
    logic [7:0]  col;
    logic [31:0] value;
  } pdm_beat_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] index;
    logic [15:0]          data;
  } reg_write_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  pdmfir_in_if  pdm_in_bus ();
  pdmfir_out_if pcm_out_bus ();
  pdmfir_cfg_if cfg_bus ();

  pdm_to_pcm_fir_decimator_core uut (
    .clk    (clk),
    .rst    (rst),
    .pdm_in (pdm_in_bus),
    .pcm_out(pcm_out_bus),
    .cfg    (cfg_bus)
  );

  // Stimulus and expectation stores
  pdm_beat_t   beat_queue[$];
  reg_write_t  reg_queue[$];
  logic [15:0] pcm_expect_q[$];

  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  int unsigned hold_asked  = 0;

  // Filter state as the core should hold it
  logic [15:0] ring_model [TAPS];
  logic [31:0] coeff_model [TABLE_DEPTH];
  int unsigned slot_model;
  int unsigned group_count;
  logic [4:0]  dec_words_reg;
  logic [15:0] in_off_reg;
  logic [15:0] out_off_reg;
  logic [15:0] gain_reg;
  logic [3:0]  bit_scale_reg;

  int unsigned words_taken     = 0;
  int unsigned table_writes    = 0;
  int unsigned reg_writes      = 0;
  int unsigned samples_checked = 0;
  int unsigned error_count     = 0;
  int unsigned quiet_cycles    = 0;

  always begin
    #HALF_PERIOD clk = 1'b1;
    #HALF_PERIOD clk = 1'b0;
  end

  // PCM sample from the current ring window, oldest word first
  function automatic logic [15:0] next_pcm_sample();
    logic [31:0] acc;
    logic [15:0] w;
    int unsigned bs;
    int unsigned sh;
    longint v;
    longint lim;
    acc = '0;
    for (int unsigned k = 0; k < TAPS; k++) begin
      w = ring_model[(slot_model + k) % TAPS];
      acc += coeff_model[(2 * k) * 256 + w[15:8]];
      acc += coeff_model[(2 * k + 1) * 256 + w[7:0]];
    end
    bs  = (bit_scale_reg == 4'd0) ? 1 : bit_scale_reg;
    sh  = SCALE_BITS + 1 - bs;
    lim = longint'(1) << (bs - 1);
    v   = longint'($signed(acc)) >>> sh;
    v   = v + longint'($signed(in_off_reg));
    v   = v * longint'(gain_reg);
    if (v > lim - 1) v = lim - 1;
    if (v < -lim) v = -lim;
    v = v + longint'($signed(out_off_reg));
    return 16'(v) & 16'((32'd1 << (bs + 1)) - 32'd1);
  endfunction

  // Partial sum of random magnitude, both signs
  function automatic logic [31:0] rand_partial_sum();
    logic signed [31:0] s;
    s = $urandom;
    return s >>> $urandom_range(0, 31);
  endfunction

  // Random PDM word whose two bytes come from the filled columns
  function automatic logic [15:0] rand_word();
    int unsigned hi;
    int unsigned lo;
    hi = $urandom_range(0, SET_SIZE - 1);
    lo = $urandom_range(0, SET_SIZE - 1);
    return {BYTE_SET[8*hi +: 8], BYTE_SET[8*lo +: 8]};
  endfunction

  // Input driver: may offer a new beat whenever the channel is free, idling at random
  always @(posedge clk) begin
    pdm_beat_t nb;
    if (rst) begin
      pdm_in_bus.valid <= 1'b0;
    end else if (!pdm_in_bus.valid || pdm_in_bus.ready) begin
      if (beat_queue.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
        nb = beat_queue.pop_front();
        pdm_in_bus.valid       <= 1'b1;
        pdm_in_bus.func        <= nb.func;
        pdm_in_bus.pdm_word    <= nb.word;
        pdm_in_bus.coeff_row   <= nb.row;
        pdm_in_bus.coeff_byte  <= nb.col;
        pdm_in_bus.coeff_value <= nb.value;
      end else begin
        pdm_in_bus.valid <= 1'b0;
      end
    end
  end

  // Register write driver
  always @(posedge clk) begin
    reg_write_t rw;
    if (rst) begin
      cfg_bus.valid <= 1'b0;
    end else if (!cfg_bus.valid || cfg_bus.ready) begin
      if (reg_queue.size() != 0) begin
        rw = reg_queue.pop_front();
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= rw.index;
        cfg_bus.data  <= rw.data;
      end else begin
        cfg_bus.valid <= 1'b0;
      end
    end
  end

  // Sample receiver: random stalls, plus a long hold when asked
  always @(posedge clk) begin
    int unsigned hold_given;
    int unsigned hold_left;
    if (rst) begin
      pcm_out_bus.ready <= 1'b0;
      hold_given = 0;
      hold_left  = 0;
    end else begin
      if (hold_asked != hold_given) begin
        hold_given++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        pcm_out_bus.ready <= 1'b0;
      end else begin
        pcm_out_bus.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  // Monitor: tracks register and input beats, checks each sample, watchdog
  always @(posedge clk) begin
    logic        moved;
    logic [15:0] want;
    int unsigned dw_eff;
    moved = 1'b0;
    if (rst) begin
      for (int k = 0; k < TAPS; k++) ring_model[k] = RING_RESET;
      slot_model    = 0;
      group_count   = 0;
      dec_words_reg = 5'd4;
      in_off_reg    = 16'd0;
      out_off_reg   = 16'd0;
      gain_reg      = 16'd1;
      bit_scale_reg = 4'd15;
      quiet_cycles  = 0;
    end else begin
      if (cfg_bus.valid && cfg_bus.ready) begin
        moved = 1'b1;
        reg_writes++;
        case (cfg_bus.index)
          REG_DECIMATION_WORDS: dec_words_reg = cfg_bus.data[4:0];
          REG_INPUT_OFFSET:     in_off_reg    = cfg_bus.data;
          REG_OUTPUT_OFFSET:    out_off_reg   = cfg_bus.data;
          REG_LINEAR_GAIN:      gain_reg      = cfg_bus.data;
          REG_BIT_SCALE:        bit_scale_reg = cfg_bus.data[3:0];
          default: ;
        endcase
      end

      if (pcm_out_bus.valid && pcm_out_bus.ready) begin
        moved = 1'b1;
        if (pcm_expect_q.size() == 0) begin
          $error("pcm_sample: beat 0x%04h with no sample expected", pcm_out_bus.pcm_sample);
          error_count++;
        end else begin
          want = pcm_expect_q.pop_front();
          samples_checked++;
          if (pcm_out_bus.pcm_sample !== want) begin
            $error("pcm_sample mismatch: expected 0x%04h, actual 0x%04h",
                   want, pcm_out_bus.pcm_sample);
            error_count++;
          end
        end
      end

      if (pdm_in_bus.valid && pdm_in_bus.ready) begin
        moved = 1'b1;
        if (pdm_in_bus.func == FUNC_COEFF) begin
          table_writes++;
          if (pdm_in_bus.coeff_row < ROWS)
            coeff_model[int'(pdm_in_bus.coeff_row) * 256 + int'(pdm_in_bus.coeff_byte)] =
              pdm_in_bus.coeff_value;
        end else begin
          words_taken++;
          ring_model[slot_model] = pdm_in_bus.pdm_word;
          slot_model = (slot_model + 1) % TAPS;
          dw_eff = (dec_words_reg == 5'd0) ? 1 : (dec_words_reg > 5'd16) ? 16 : dec_words_reg;
          group_count++;
          if (group_count < dw_eff) begin
            group_count &= 15;
          end else begin
            group_count = 0;
            pcm_expect_q.push_back(next_pcm_sample());
          end
        end
      end

      // Watchdog on cycles with no beat on any channel
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  task automatic push_word(input logic [15:0] w);
    beat_queue.push_back('{FUNC_PDM, w, 5'd0, 8'd0, 32'd0});
  endtask

  task automatic push_coeff(input logic [4:0] row, input logic [7:0] col,
                            input logic [31:0] value);
    beat_queue.push_back('{FUNC_COEFF, 16'd0, row, col, value});
  endtask

  // Wait until every beat is in and every sample out, then let the core go idle
  task automatic settle();
    do @(negedge clk);
    while (beat_queue.size() != 0 || pdm_in_bus.valid || pcm_expect_q.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input pdmfir_reg_t idx, input logic [15:0] value);
    reg_queue.push_back('{idx, value});
    do @(negedge clk);
    while (reg_queue.size() != 0 || cfg_bus.valid);
  endtask

  // All five registers; unused upper data bits carry noise
  task automatic configure(input logic [4:0] dw, input logic [15:0] in_off,
                           input logic [15:0] out_off, input logic [15:0] gain,
                           input logic [3:0] bs);
    write_reg(REG_DECIMATION_WORDS, {11'($urandom), dw});
    write_reg(REG_INPUT_OFFSET, in_off);
    write_reg(REG_OUTPUT_OFFSET, out_off);
    write_reg(REG_LINEAR_GAIN, gain);
    write_reg(REG_BIT_SCALE, {12'($urandom), bs});
  endtask

  initial begin
    int p;
    int i;
    pdm_in_bus.valid       = 1'b0;
    pdm_in_bus.func        = FUNC_PDM;
    pdm_in_bus.pdm_word    = '0;
    pdm_in_bus.coeff_row   = '0;
    pdm_in_bus.coeff_byte  = '0;
    pdm_in_bus.coeff_value = '0;
    pcm_out_bus.ready      = 1'b0;
    cfg_bus.valid          = 1'b0;
    cfg_bus.index          = '0;
    cfg_bus.data           = '0;

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // The core never clears its table, so fill every column a word can reach
    tx_idle_pct = 37;
    rx_idle_pct = 50;
    for (i = 0; i < ROWS * SET_SIZE; i++)
      push_coeff(5'(i / SET_SIZE), BYTE_SET[8*(i % SET_SIZE) +: 8], rand_partial_sum());
    settle();

    // Extreme partial sums, then one group at reset settings over the 0x5555 ring
    push_coeff(5'd0, 8'h00, 32'h7FFF_FFFF);
    push_coeff(5'd31, 8'hFF, 32'h8000_0000);
    push_coeff(5'd1, 8'hFF, 32'hFFFF_FFFF);
    push_word(16'h0000);
    push_word(16'hFFFF);
    push_word(16'h00FF);
    push_word(16'hFF00);
    settle();

    // Factor of zero behaves as one; zero bit scale; full gain, extreme offsets
    configure(5'd0, 16'h8000, 16'h7FFF, 16'hFFFF, 4'd0);
    push_word(16'hA5A5);
    settle();

    // Words left over under an oversized factor, then the factor dropped below them
    configure(5'd31, 16'h7FFF, 16'h8000, 16'd1, 4'd15);
    repeat (5) push_word(rand_word());
    settle();
    write_reg(REG_DECIMATION_WORDS, 16'd3);
    push_word(16'h8001);
    settle();

    // Zero gain at the coarsest resolution
    configure(5'd3, 16'h0000, 16'h0000, 16'h0000, 4'd1);
    repeat (3) push_word(rand_word());

    // Random phases: receiver-heavy idling, sender-heavy idling, then none
    for (p = 0; p < PHASES; p++) begin
      settle();
      case (p / 3)
        0: begin tx_idle_pct = 37; rx_idle_pct = 50; end
        1: begin tx_idle_pct = 50; rx_idle_pct = 37; end
        default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
      endcase
      case (p)
        0: configure(5'd1, 16'h8000, 16'h7FFF, 16'hFFFF, 4'd1);
        1: configure(5'd16, 16'h7FFF, 16'h8000, 16'd1, 4'd15);
        default: configure(
          ($urandom_range(0, 4) == 0) ? 5'($urandom_range(0, 31)) : 5'($urandom_range(1, 6)),
          ($urandom_range(0, 2) == 0) ? 16'($urandom) : 16'($signed(8'($urandom))),
          ($urandom_range(0, 2) == 0) ? 16'($urandom) : 16'($signed(8'($urandom))),
          ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 8)),
          4'($urandom_range(0, 15)));
      endcase
      for (i = 0; i < PHASE_BEATS; i++) begin
        if ($urandom_range(0, 9) == 0)
          push_coeff(5'($urandom), 8'($urandom), rand_partial_sum());
        else
          push_word(rand_word());
      end
      // One sample per word here, so a long receiver hold backs up the input
      if (p == 0) hold_asked++;
    end

    settle();
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Run covered %0d PDM words, %0d table writes and %0d register writes;",
             words_taken, table_writes, reg_writes);
    $display("%0d PCM samples compared, %0d mismatches.", samples_checked, error_count);
    if (error_count == 0 && pcm_expect_q.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
